// ----- hw/rtl/pidp_pkg.sv -----
// Package for the PID position controller: widths, register codes, sequencer states,
// controller-to-datapath command struct and fixed-point helper functions.
// No dependencies.
package pidp_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_REGS   = 8;
    localparam int IDX_WIDTH  = $clog2(NUM_REGS);
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH  = DATA_WIDTH + 2;

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic        [DATA_WIDTH-2:0] t_lim;
    typedef logic signed [DATA_WIDTH:0]   t_ext;
    typedef logic signed [SUM_WIDTH-1:0]  t_sum;
    typedef logic signed [PROD_WIDTH-1:0] t_prod;

    localparam t_word WORD_MAX = t_word'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam t_word WORD_MIN = ~WORD_MAX;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_STEP_TIME      = 3'd3,
        REG_STEP_RATE      = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_OUTPUT_LIMIT   = 3'd6,
        REG_FORCE_GAIN     = 3'd7
    } t_reg_idx;

    localparam t_word RST_GAIN_P         = t_word'(2621);
    localparam t_word RST_GAIN_I         = t_word'(328);
    localparam t_word RST_GAIN_D         = t_word'(5243);
    localparam t_lim  RST_STEP_TIME      = t_lim'(66);
    localparam t_lim  RST_STEP_RATE      = t_lim'(65536000);
    localparam t_lim  RST_INTEGRAL_LIMIT = t_lim'(1310720);
    localparam t_lim  RST_OUTPUT_LIMIT   = t_lim'(13726);
    localparam t_word RST_FORCE_GAIN     = t_word'(262144);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_R,
        ST_MUL_P,
        ST_MUL_TI,
        ST_MUL_D,
        ST_SUM_D,
        ST_SUM_CMD,
        ST_MUL_F,
        ST_WRITE
    } t_state;

    typedef enum logic [2:0] {
        MUL_ERR_ST,
        MUL_DIFF_SR,
        MUL_GP_ERR,
        MUL_GI_INT,
        MUL_GD_RATE,
        MUL_CMD_FG
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     calc_diff;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_integ;
        logic     ld_rate;
        logic     ld_p;
        logic     ld_i;
        logic     ld_d;
        logic     ld_cmd;
        logic     ld_out;
    } t_cmd;

    // saturate a one-bit-grown sum to the word
    function automatic t_word sat_ext(input t_ext s);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // product >>> FRAC_BITS (floor), saturated to the word
    function automatic t_word fx_sat(input t_prod p);
        t_prod s;
        s = p >>> FRAC_BITS;
        if ((&s[PROD_WIDTH-1:DATA_WIDTH-1]) || !(|s[PROD_WIDTH-1:DATA_WIDTH-1])) begin
            return s[DATA_WIDTH-1:0];
        end
        return s[PROD_WIDTH-1] ? WORD_MIN : WORD_MAX;
    endfunction

    function automatic t_sum clamp_sym(input t_sum v, input t_lim lim);
        t_sum hi;
        t_sum lo;
        hi = t_sum'(lim);
        lo = -hi;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/pidp_ctrl.sv -----
// Sequencer for the PID position controller: steps the shared multiplier schedule
// and owns the input ready and output valid handshakes. Depends on pidp_pkg.
module pidp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pidp_pkg::t_cmd o_cmd
);
    import pidp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_MUL_I;
            ST_MUL_I:   n_state = ST_MUL_R;
            ST_MUL_R:   n_state = ST_MUL_P;
            ST_MUL_P:   n_state = ST_MUL_TI;
            ST_MUL_TI:  n_state = ST_MUL_D;
            ST_MUL_D:   n_state = ST_SUM_D;
            ST_SUM_D:   n_state = ST_SUM_CMD;
            ST_SUM_CMD: n_state = ST_MUL_F;
            ST_MUL_F:   n_state = ST_WRITE;
            ST_WRITE:   if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (r_state)
            ST_IDLE:    cmd.load_in = i_in_valid;
            ST_MUL_I: begin
                cmd.calc_diff = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_ERR_ST;
            end
            ST_MUL_R: begin
                cmd.upd_integ = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DIFF_SR;
            end
            ST_MUL_P: begin
                cmd.ld_rate = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GP_ERR;
            end
            ST_MUL_TI: begin
                cmd.ld_p    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GI_INT;
            end
            ST_MUL_D: begin
                cmd.ld_i    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GD_RATE;
            end
            ST_SUM_D:   cmd.ld_d = 1'b1;
            ST_SUM_CMD: cmd.ld_cmd = 1'b1;
            ST_MUL_F: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CMD_FG;
            end
            ST_WRITE:   cmd.ld_out = !r_out_valid || i_out_ready;
            default:    cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- hw/rtl/pidp_datapath.sv -----
// Datapath for the PID position controller: configuration registers, loop state,
// shared registered multiplier, clamps and the output register. Depends on pidp_pkg.
module pidp_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pidp_pkg::IDX_WIDTH-1:0] i_cfg_index,
    input  pidp_pkg::t_word               i_cfg_data,
    input  pidp_pkg::t_cmd                i_cmd,
    input  pidp_pkg::t_word               i_position,
    output pidp_pkg::t_word               o_error_value,
    output pidp_pkg::t_word               o_p_term,
    output pidp_pkg::t_word               o_i_term,
    output pidp_pkg::t_word               o_d_term,
    output pidp_pkg::t_word               o_command,
    output pidp_pkg::t_word               o_drive_force
);
    import pidp_pkg::*;

    t_word r_gain_p, r_gain_i, r_gain_d, r_force_gain;
    t_lim  r_step_time, r_step_rate, r_integral_limit, r_output_limit;

    t_word r_acc, r_last;
    t_word r_err, r_diff, r_rate, r_p, r_i, r_d, r_cmd;
    t_prod r_prod;

    t_word r_out_err, r_out_p, r_out_i, r_out_d, r_out_cmd, r_out_force;

    t_word op_a, op_b;
    t_word prod_fx;
    t_sum  integ_sum, integ_clamped;
    t_sum  term_sum, term_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p         <= RST_GAIN_P;
            r_gain_i         <= RST_GAIN_I;
            r_gain_d         <= RST_GAIN_D;
            r_step_time      <= RST_STEP_TIME;
            r_step_rate      <= RST_STEP_RATE;
            r_integral_limit <= RST_INTEGRAL_LIMIT;
            r_output_limit   <= RST_OUTPUT_LIMIT;
            r_force_gain     <= RST_FORCE_GAIN;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GAIN_P:         r_gain_p         <= i_cfg_data;
                REG_GAIN_I:         r_gain_i         <= i_cfg_data;
                REG_GAIN_D:         r_gain_d         <= i_cfg_data;
                REG_STEP_TIME:      r_step_time      <= i_cfg_data[DATA_WIDTH-2:0];
                REG_STEP_RATE:      r_step_rate      <= i_cfg_data[DATA_WIDTH-2:0];
                REG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data[DATA_WIDTH-2:0];
                REG_OUTPUT_LIMIT:   r_output_limit   <= i_cfg_data[DATA_WIDTH-2:0];
                REG_FORCE_GAIN:     r_force_gain     <= i_cfg_data;
                default:            r_gain_p         <= r_gain_p;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_ERR_ST: begin
                op_a = r_err;
                op_b = t_word'({1'b0, r_step_time});
            end
            MUL_DIFF_SR: begin
                op_a = r_diff;
                op_b = t_word'({1'b0, r_step_rate});
            end
            MUL_GP_ERR: begin
                op_a = r_gain_p;
                op_b = r_err;
            end
            MUL_GI_INT: begin
                op_a = r_gain_i;
                op_b = r_acc;
            end
            MUL_GD_RATE: begin
                op_a = r_gain_d;
                op_b = r_rate;
            end
            MUL_CMD_FG: begin
                op_a = r_cmd;
                op_b = r_force_gain;
            end
            default: begin
                op_a = r_err;
                op_b = r_err;
            end
        endcase
    end

    assign prod_fx       = fx_sat(r_prod);
    assign integ_sum     = t_sum'(r_acc) + t_sum'(prod_fx);
    assign integ_clamped = clamp_sym(integ_sum, r_integral_limit);
    assign term_sum      = t_sum'(r_p) + t_sum'(r_i) + t_sum'(r_d);
    assign term_clamped  = clamp_sym(term_sum, r_output_limit);

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_last <= '0;
        end else if (i_cmd.upd_integ) begin
            r_acc  <= integ_clamped[DATA_WIDTH-1:0];
            r_last <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_err <= sat_ext(t_ext'(0) - t_ext'(i_position));
        end
        if (i_cmd.calc_diff) begin
            r_diff <= sat_ext(t_ext'(r_err) - t_ext'(r_last));
        end
        if (i_cmd.mul_en) begin
            r_prod <= t_prod'(op_a) * t_prod'(op_b);
        end
        if (i_cmd.ld_rate) r_rate <= prod_fx;
        if (i_cmd.ld_p)    r_p    <= prod_fx;
        if (i_cmd.ld_i)    r_i    <= prod_fx;
        if (i_cmd.ld_d)    r_d    <= prod_fx;
        if (i_cmd.ld_cmd)  r_cmd  <= term_clamped[DATA_WIDTH-1:0];
        if (i_cmd.ld_out) begin
            r_out_err   <= r_err;
            r_out_p     <= r_p;
            r_out_i     <= r_i;
            r_out_d     <= r_d;
            r_out_cmd   <= r_cmd;
            r_out_force <= prod_fx;
        end
    end

    assign o_error_value = r_out_err;
    assign o_p_term      = r_out_p;
    assign o_i_term      = r_out_i;
    assign o_d_term      = r_out_d;
    assign o_command     = r_out_cmd;
    assign o_drive_force = r_out_force;

endmodule

// ----- hw/rtl/pid_position_controller_unit.sv -----
// Top level of the PID position controller: sequencer plus datapath.
// Depends on pidp_pkg, pidp_ctrl and pidp_datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//  input    | i_in_valid / o_in_ready    | i_position
//  output   | o_out_valid / i_out_ready  | o_error_value, o_p_term, o_i_term,
//           |                            | o_d_term, o_command, o_drive_force
//
// An item is accepted in idle, then runs its six products in sequence through the
// single registered multiplier, two sum steps and the output write, and only then
// returns to idle; so a new item is not taken before the last one's result has been
// written to the output register.
// The finished result sits in an output register, so the block goes back to accepting
// while it waits; a new result waits in the last step until that register is free.
// Reset is synchronous, active low: registers return to their defaults, loop state to 0.
module pid_position_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pidp_pkg::IDX_WIDTH-1:0] i_cfg_index,
    input  pidp_pkg::t_word               i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pidp_pkg::t_word               i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pidp_pkg::t_word               o_error_value,
    output pidp_pkg::t_word               o_p_term,
    output pidp_pkg::t_word               o_i_term,
    output pidp_pkg::t_word               o_d_term,
    output pidp_pkg::t_word               o_command,
    output pidp_pkg::t_word               o_drive_force
);
    import pidp_pkg::*;

    t_cmd cmd;

    pidp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    pidp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_position    (i_position),
        .o_error_value (o_error_value),
        .o_p_term      (o_p_term),
        .o_i_term      (o_i_term),
        .o_d_term      (o_d_term),
        .o_command     (o_command),
        .o_drive_force (o_drive_force)
    );

endmodule

// ----- hw/rtl/pidp_checker.sv -----
// Port-level checker for the PID position controller, bound to the top level.
// Depends on pidp_pkg and pid_position_controller_unit.
module pidp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input pidp_pkg::t_word o_error_value,
    input pidp_pkg::t_word o_command,
    input pidp_pkg::t_word o_drive_force
);
    import pidp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive_force))
        else $error("output item dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after an item");

    // clamp to a symmetric limit never reaches the most negative word
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_command != WORD_MIN)
        else $error("command outside symmetric clamp");

    // negated position saturates, so the most negative word cannot appear
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_value != WORD_MIN)
        else $error("error value not saturated");

endmodule

bind pid_position_controller_unit pidp_checker u_pidp_checker (.*);
